// ===== src/v4n_pkg.sv =====
`timescale 1ns / 1ps
package v4n_pkg;
    localparam int CW = 16;                  // component width
    localparam int FB = 12;                  // input fraction bits
    localparam int OF = CW - 2;              // output fraction bits
    localparam int MW = CW;                  // magnitude width (holds 2^(CW-1))
    localparam int SW = 2 * CW + 2;          // sum of squares width
    localparam int RW = CW + 1;              // root width
    localparam int NW = MW + OF;             // dividend width
    localparam int QW = NW;                  // quotient width
    localparam int NC = 4;                   // vector components

    typedef logic signed [CW-1:0] comp_t;
    typedef logic [MW-1:0] mag_t;
    typedef logic [SW-1:0] sum_t;
    typedef logic [RW-1:0] root_t;
    typedef logic [QW-1:0] quo_t;
endpackage

// ===== src/v4n_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined restoring square root, one result bit per stage.
module v4n_sqrt (
    input  logic          clk,
    input  logic          en,
    input  v4n_pkg::sum_t rad,
    output v4n_pkg::root_t root
);
    import v4n_pkg::*;

    sum_t  rem_reg  [RW+1];
    root_t root_reg [RW+1];

    assign root = root_reg[RW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rad;
            root_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        localparam int B = RW - 1 - s;
        logic [SW+1:0] trial;
        logic [SW+1:0] rem_ext;
        always_comb
        begin
            trial   = ({{(SW+2-RW){1'b0}}, root_reg[s]} << (B + 1))
                      | ({{(SW+1){1'b0}}, 1'b1} << (2 * B));
            rem_ext = {2'b00, rem_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_ext >= trial)
                begin
                    rem_reg[s+1]  <= SW'(rem_ext - trial);
                    root_reg[s+1] <= root_reg[s] | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[s+1]  <= rem_reg[s];
                    root_reg[s+1] <= root_reg[s];
                end
            end
        end
    end
endmodule

// ===== src/v4n_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module v4n_div (
    input  logic           clk,
    input  logic           en,
    input  v4n_pkg::mag_t  num,
    input  v4n_pkg::root_t den,
    output v4n_pkg::quo_t  quo
);
    import v4n_pkg::*;

    logic [RW-1:0] rem_reg [QW+1];
    logic [NW-1:0] n_reg   [QW+1];
    root_t         d_reg   [QW+1];
    quo_t          q_reg   [QW+1];

    assign quo = q_reg[QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            n_reg[0]   <= {num, {OF{1'b0}}};
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [RW:0] part;
        assign part = {rem_reg[s], n_reg[s][NW-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= n_reg[s] << 1;
                d_reg[s+1] <= d_reg[s];
                if (part >= {1'b0, d_reg[s]})
                begin
                    rem_reg[s+1] <= RW'(part - {1'b0, d_reg[s]});
                    q_reg[s+1]   <= {q_reg[s][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= part[RW-1:0];
                    q_reg[s+1]   <= {q_reg[s][QW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// ===== src/vector4_normalize.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// request  | in_valid / in_ready  | in_w in_x in_y in_z (signed Q4.12)
// result   | out_valid / out_ready| out_w..out_z (signed Q2.14), vector_length, was_zero
//
// One request per cycle is taken while in_ready is high. Each request
// passes 3 + 18 + 31 + 1 = 53 register stages: magnitude, squares, sum,
// an 18-stage root (load plus 17 bits), a 31-stage divider (load plus
// 30 bits) and the output register.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage. Reset clears the valid bits only.
module vector4_normalize (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  v4n_pkg::comp_t in_w,
    input  v4n_pkg::comp_t in_x,
    input  v4n_pkg::comp_t in_y,
    input  v4n_pkg::comp_t in_z,
    output logic           out_valid,
    input  logic           out_ready,
    output v4n_pkg::comp_t out_w,
    output v4n_pkg::comp_t out_x,
    output v4n_pkg::comp_t out_y,
    output v4n_pkg::comp_t out_z,
    output logic [v4n_pkg::RW-1:0] vector_length,
    output logic           was_zero
);
    import v4n_pkg::*;

    localparam int LAT = 5 + RW + QW;  // register stages from input to divider output

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // valid and sign/root side pipeline
    logic [LAT-1:0] vld_reg;
    logic [NC-1:0]  neg_reg [LAT];
    root_t          len_reg [QW+1];

    // stage 1: magnitudes
    mag_t mag_reg [NC];
    // stage 2: squares
    logic [2*CW-1:0] sq_reg [NC];
    // stage 3: sum
    sum_t sum_reg;
    // magnitudes follow into divider input, aligned at root output
    mag_t mg_reg [RW+3][NC];

    comp_t in_c [NC];
    assign in_c = '{in_w, in_x, in_y, in_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NC; i++)
            begin
                mag_reg[i] <= in_c[i][CW-1] ? mag_t'(-in_c[i]) : mag_t'(in_c[i]);
                sq_reg[i]  <= mag_reg[i] * mag_reg[i];
            end
            neg_reg[0] <= {in_c[3][CW-1], in_c[2][CW-1], in_c[1][CW-1], in_c[0][CW-1]};
            for (int k = 1; k < LAT; k++)
                neg_reg[k] <= neg_reg[k-1];
            sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
            mg_reg[0] <= mag_reg;
            for (int k = 1; k < RW + 3; k++)
                mg_reg[k] <= mg_reg[k-1];
        end
    end

    root_t root;
    v4n_sqrt u_sqrt (.clk(clk), .en(en), .rad(sum_reg), .root(root));

    // root is valid alongside vld_reg[3+RW]; carry it through the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= root;
            for (int k = 1; k < QW + 1; k++)
                len_reg[k] <= len_reg[k-1];
        end
    end

    // mg_reg[RW+2] aligns with root (3 stages + RW + 1 after input, minus 2 from mag_reg and mg_reg[0])
    quo_t quo [NC];
    for (genvar c = 0; c < NC; c++)
    begin : g_div
        v4n_div u_div (.clk(clk), .en(en), .num(mg_reg[RW+2][c]), .den(root),
                       .quo(quo[c]));
    end

    localparam quo_t ONE = quo_t'(1) << OF;

    comp_t o_reg [NC];
    root_t l_reg;
    logic  z_reg;
    logic  ov_reg;
    assign out_valid     = ov_reg;
    assign out_w         = o_reg[0];
    assign out_x         = o_reg[1];
    assign out_y         = o_reg[2];
    assign out_z         = o_reg[3];
    assign vector_length = l_reg;
    assign was_zero      = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= vld_reg[LAT-1];
    end

    root_t flen;
    assign flen = len_reg[QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NC; i++)
            begin
                if (flen == '0)
                    o_reg[i] <= '0;
                else if (quo[i] > ONE)
                    o_reg[i] <= neg_reg[LAT-1][i] ? comp_t'(-ONE) : comp_t'(ONE);
                else
                    o_reg[i] <= neg_reg[LAT-1][i] ? comp_t'(-quo[i]) : comp_t'(quo[i]);
            end
            l_reg <= flen;
            z_reg <= (flen == '0);
        end
    end
endmodule
